[rtl/lei_pkg.sv]
package lei_pkg;

   localparam int COORD_BITS    = 32;
   localparam int FRACTION_BITS = 24;
   localparam int GAIN_BITS     = 31;
   localparam int COUNT_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CYC_BITS      = 4;

   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic signed [COORD_BITS:0]     wide_type;
   typedef logic signed [2*COORD_BITS-1:0] prod_type;
   typedef logic [GAIN_BITS-1:0]           gain_type;
   typedef logic [COUNT_BITS-1:0]          count_type;
   typedef logic [CYC_BITS-1:0]            cyc_type;

   localparam coord_type CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam gain_type  SIGMA_RESET = GAIN_BITS'(167772160);
   localparam gain_type  BETA_RESET  = GAIN_BITS'(44739242);
   localparam gain_type  RHO_RESET   = GAIN_BITS'(469762048);
   localparam gain_type  STEP_RESET  = GAIN_BITS'(16777);
   localparam coord_type START_RESET = COORD_BITS'(16777216);
   localparam count_type LEN_RESET   = COUNT_BITS'(50000);

   // last issue/capture slot of the run phase
   localparam cyc_type RUN_LAST = CYC_BITS'(8);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SIGMA,
      CSR_BETA,
      CSR_RHO,
      CSR_STEP,
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z,
      CSR_LENGTH
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      TAG_DX,
      TAG_XR,
      TAG_XY,
      TAG_BZ,
      TAG_NX,
      TAG_NY,
      TAG_NZ
   } tag_type;

   typedef struct packed {
      gain_type  sigma;
      gain_type  beta;
      gain_type  rho;
      gain_type  dt;
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      count_type length;
   } cfg_type;

   typedef struct packed {
      logic      valid;
      tag_type   tag;
      coord_type a;
      coord_type b;
   } mul_req_type;

   typedef struct packed {
      logic      valid;
      tag_type   tag;
      coord_type value;
   } mul_rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      count_type index;
      logic      last;
   } result_type;

   function automatic coord_type gain_to_coord(gain_type g);
      return {{(COORD_BITS-GAIN_BITS){1'b0}}, g};
   endfunction

   function automatic coord_type clamp_wide(wide_type s);
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         return s[COORD_BITS] ? CMIN : CMAX;
      end
      return s[COORD_BITS-1:0];
   endfunction

   function automatic coord_type sat_add(coord_type a, coord_type b);
      wide_type s;
      s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      return clamp_wide(s);
   endfunction

   function automatic coord_type sat_sub(coord_type a, coord_type b);
      wide_type s;
      s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return clamp_wide(s);
   endfunction

   // floor(p / 2^FRACTION_BITS), clamped
   function automatic coord_type mul_round(prod_type p);
      prod_type q;
      q = p >>> FRACTION_BITS;
      if ((&q[2*COORD_BITS-1:COORD_BITS-1]) || !(|q[2*COORD_BITS-1:COORD_BITS-1])) begin
         return q[COORD_BITS-1:0];
      end
      return q[2*COORD_BITS-1] ? CMIN : CMAX;
   endfunction

endpackage

[rtl/lei_mul_unit.sv]
module lei_mul_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  lei_pkg::mul_req_type req,
   output lei_pkg::mul_rsp_type rsp
);

   logic               s1_valid_ff, s1_valid_in;
   lei_pkg::tag_type   s1_tag_ff, s1_tag_in;
   lei_pkg::prod_type  prod_ff, prod_in;
   logic               s2_valid_ff, s2_valid_in;
   lei_pkg::tag_type   s2_tag_ff, s2_tag_in;
   lei_pkg::coord_type value_ff, value_in;

   always_comb begin
      s1_valid_in = req.valid;
      s1_tag_in   = req.tag;
      prod_in     = $signed(req.a) * $signed(req.b);
      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;
      value_in    = lei_pkg::mul_round(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= s1_tag_in;
      prod_ff   <= prod_in;
      s2_tag_ff <= s2_tag_in;
      value_ff  <= value_in;
   end

   assign rsp.valid = s2_valid_ff;
   assign rsp.tag   = s2_tag_ff;
   assign rsp.value = value_ff;

endmodule

[rtl/lei_core.sv]
module lei_core (
   input  logic                 clock,
   input  logic                 reset,
   input  lei_pkg::cfg_type     cfg,
   input  logic                 start,
   input  logic                 restart,
   input  logic                 out_free,
   output logic                 idle,
   output logic                 done,
   output lei_pkg::result_type  result
);

   lei_pkg::state_type   state_ff, state_in;
   lei_pkg::cyc_type     cyc_ff, cyc_in;
   lei_pkg::coord_type   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   lei_pkg::count_type   count_ff, count_in;
   lei_pkg::coord_type   t1_ff, t1_in, t2_ff, t2_in;
   lei_pkg::coord_type   dx_ff, dx_in, dy_ff, dy_in, xy_ff, xy_in, dz_ff, dz_in;
   lei_pkg::coord_type   nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   lei_pkg::mul_req_type mul_req;
   lei_pkg::mul_rsp_type mul_rsp;
   lei_pkg::count_type   len;
   logic                 last;

   lei_mul_unit u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      cyc_in   = cyc_ff;
      unique case (state_ff)
         lei_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lei_pkg::ST_PREP;
            end
         end
         lei_pkg::ST_PREP: begin
            state_in = lei_pkg::ST_RUN;
            cyc_in   = '0;
         end
         lei_pkg::ST_RUN: begin
            cyc_in = cyc_ff + lei_pkg::CYC_BITS'(1);
            if (cyc_ff == lei_pkg::RUN_LAST) begin
               state_in = lei_pkg::ST_FINISH;
            end
         end
         lei_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = lei_pkg::ST_IDLE;
            end
         end
         default: state_in = lei_pkg::ST_IDLE;
      endcase
   end

   // outputs: multiplier issue schedule and handshakes
   always_comb begin
      mul_req.valid = 1'b0;
      mul_req.tag   = lei_pkg::TAG_DX;
      mul_req.a     = lei_pkg::gain_to_coord(cfg.sigma);
      mul_req.b     = t1_ff;
      idle          = 1'b0;
      done          = 1'b0;
      unique case (state_ff)
         lei_pkg::ST_IDLE:   idle = 1'b1;
         lei_pkg::ST_PREP:   ;
         lei_pkg::ST_RUN: begin
            case (cyc_ff)
               lei_pkg::CYC_BITS'(0): begin
                  mul_req.valid = 1'b1;
               end
               lei_pkg::CYC_BITS'(1): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_XR;
                  mul_req.a     = x_ff;
                  mul_req.b     = t2_ff;
               end
               lei_pkg::CYC_BITS'(2): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_XY;
                  mul_req.a     = x_ff;
                  mul_req.b     = y_ff;
               end
               lei_pkg::CYC_BITS'(3): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_BZ;
                  mul_req.a     = lei_pkg::gain_to_coord(cfg.beta);
                  mul_req.b     = z_ff;
               end
               lei_pkg::CYC_BITS'(4): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_NX;
                  mul_req.a     = lei_pkg::gain_to_coord(cfg.dt);
                  mul_req.b     = dx_ff;
               end
               lei_pkg::CYC_BITS'(5): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_NY;
                  mul_req.a     = lei_pkg::gain_to_coord(cfg.dt);
                  mul_req.b     = dy_ff;
               end
               lei_pkg::CYC_BITS'(6): begin
                  mul_req.valid = 1'b1;
                  mul_req.tag   = lei_pkg::TAG_NZ;
                  mul_req.a     = lei_pkg::gain_to_coord(cfg.dt);
                  mul_req.b     = dz_ff;
               end
               default: ;
            endcase
         end
         lei_pkg::ST_FINISH: done = out_free;
         default: ;
      endcase
   end

   assign len  = (cfg.length == '0) ? lei_pkg::COUNT_BITS'(1) : cfg.length;
   assign last = count_ff >= (len - lei_pkg::COUNT_BITS'(1));

   // datapath
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      count_in = count_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      xy_in    = xy_ff;
      dz_in    = dz_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nz_in    = nz_ff;
      if (start && restart) begin
         x_in     = cfg.start_x;
         y_in     = cfg.start_y;
         z_in     = cfg.start_z;
         count_in = '0;
      end
      if (state_ff == lei_pkg::ST_PREP) begin
         t1_in = lei_pkg::sat_sub(y_ff, x_ff);
         t2_in = lei_pkg::sat_sub(lei_pkg::gain_to_coord(cfg.rho), z_ff);
      end
      if (mul_rsp.valid) begin
         case (mul_rsp.tag)
            lei_pkg::TAG_DX: dx_in = mul_rsp.value;
            lei_pkg::TAG_XR: dy_in = lei_pkg::sat_sub(mul_rsp.value, y_ff);
            lei_pkg::TAG_XY: xy_in = mul_rsp.value;
            lei_pkg::TAG_BZ: dz_in = lei_pkg::sat_sub(xy_ff, mul_rsp.value);
            lei_pkg::TAG_NX: nx_in = lei_pkg::sat_add(x_ff, mul_rsp.value);
            lei_pkg::TAG_NY: ny_in = lei_pkg::sat_add(y_ff, mul_rsp.value);
            lei_pkg::TAG_NZ: nz_in = lei_pkg::sat_add(z_ff, mul_rsp.value);
            default: ;
         endcase
      end
      if (done) begin
         x_in     = nx_ff;
         y_in     = ny_ff;
         z_in     = nz_ff;
         count_in = last ? '0 : count_ff + lei_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lei_pkg::ST_IDLE;
         cyc_ff   <= '0;
         x_ff     <= lei_pkg::START_RESET;
         y_ff     <= lei_pkg::START_RESET;
         z_ff     <= lei_pkg::START_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         cyc_ff   <= cyc_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      xy_ff <= xy_in;
      dz_ff <= dz_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nz_ff <= nz_in;
   end

   assign result.x     = nx_ff;
   assign result.y     = ny_ff;
   assign result.z     = nz_ff;
   assign result.index = count_ff;
   assign result.last  = last;

`ifndef ASSERT_OFF
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.valid |-> (state_ff == lei_pkg::ST_RUN))
      else $error("multiplier result outside run phase");

   a_cyc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lei_pkg::ST_RUN) |-> (cyc_ff <= lei_pkg::RUN_LAST))
      else $error("run slot counter out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == lei_pkg::ST_IDLE))
      else $error("core not idle after finish");

   a_run_follows_prep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lei_pkg::ST_PREP) |=> (state_ff == lei_pkg::ST_RUN && cyc_ff == '0))
      else $error("run phase did not start at slot zero");
`endif

endmodule

[rtl/lorenz_euler_integrator.sv]
// Lorenz system, one explicit Euler step per item, signed Q8.24 arithmetic.
// req channel: one item per time tick; req_restart = 1 reloads the start
//   point and clears the trace index before the step is taken.
// rsp channel: one item per request with the new point, its index within
//   the trace and a flag on the last point of the trace.
// csr channel: register writes (index 0..7: sigma, beta, rho, dt, start x,
//   y, z, trace length); always ready, write only while the block is idle.
// All seven products go through one 32x32 multiplier with two register
//   stages, issued in order over the run slots; req_ready is low while a
//   step is in progress, so a new item is taken only once the previous
//   step has finished.
// A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls, the following step
//   holds in its finish state until the output register frees up.
// Reset (synchronous, active high) loads the register defaults, sets the
//   point to (1,1,1), clears the index and empties the output register.
module lorenz_euler_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic [31:0] rsp_point_z,
   output logic [15:0] rsp_step_index,
   output logic        rsp_last_point,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   lei_pkg::cfg_type    cfg_ff, cfg_in;
   logic                out_valid_ff, out_valid_in;
   lei_pkg::result_type out_ff, out_in;
   lei_pkg::result_type result;
   logic                core_idle;
   logic                core_done;
   logic                out_free;
   logic                start;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (lei_pkg::csr_index_type'(csr_index))
            lei_pkg::CSR_SIGMA:   cfg_in.sigma   = csr_data[lei_pkg::GAIN_BITS-1:0];
            lei_pkg::CSR_BETA:    cfg_in.beta    = csr_data[lei_pkg::GAIN_BITS-1:0];
            lei_pkg::CSR_RHO:     cfg_in.rho     = csr_data[lei_pkg::GAIN_BITS-1:0];
            lei_pkg::CSR_STEP:    cfg_in.dt      = csr_data[lei_pkg::GAIN_BITS-1:0];
            lei_pkg::CSR_START_X: cfg_in.start_x = csr_data;
            lei_pkg::CSR_START_Y: cfg_in.start_y = csr_data;
            lei_pkg::CSR_START_Z: cfg_in.start_z = csr_data;
            lei_pkg::CSR_LENGTH:  cfg_in.length  = csr_data[lei_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sigma   <= lei_pkg::SIGMA_RESET;
         cfg_ff.beta    <= lei_pkg::BETA_RESET;
         cfg_ff.rho     <= lei_pkg::RHO_RESET;
         cfg_ff.dt      <= lei_pkg::STEP_RESET;
         cfg_ff.start_x <= lei_pkg::START_RESET;
         cfg_ff.start_y <= lei_pkg::START_RESET;
         cfg_ff.start_z <= lei_pkg::START_RESET;
         cfg_ff.length  <= lei_pkg::LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = core_idle;
   assign start     = req_valid && core_idle;
   assign out_free  = !out_valid_ff || rsp_ready;

   lei_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (start),
      .restart  (req_restart),
      .out_free (out_free),
      .idle     (core_idle),
      .done     (core_done),
      .result   (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (core_done) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = out_ff.x;
   assign rsp_point_y    = out_ff.y;
   assign rsp_point_z    = out_ff.z;
   assign rsp_step_index = out_ff.index;
   assign rsp_last_point = out_ff.last;

endmodule
